[design/moving_average_motion_magnitude_core_defines.svh]
// Assertion macros shared by the motion magnitude core.
`ifndef MOVING_AVERAGE_MOTION_MAGNITUDE_CORE_DEFINES_SVH
`define MOVING_AVERAGE_MOTION_MAGNITUDE_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk_i and disabled while in reset.
`define MAMM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("motion magnitude core: same-cycle check failed");

// Next-cycle implication, checked on clk_i and disabled while in reset.
`define MAMM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("motion magnitude core: next-cycle check failed");

`endif

[design/mamm_pkg.sv]
// Types and constants for the moving-average motion magnitude core.
package mamm_pkg;

  // Window length and the widths that follow from it.
  localparam int unsigned Window   = 13;
  localparam int unsigned NumAxes  = 3;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned WinBits  = $clog2(Window);
  localparam int unsigned SumW     = SampleW + WinBits;
  localparam int unsigned PosW     = (WinBits > 0) ? WinBits : 1;
  localparam int unsigned OutW     = SampleW + 2;

  // Division of a window sum magnitude by Window through a reciprocal multiply.
  // The shift is large enough that the rounded-up reciprocal is exact over
  // every magnitude below 2**(SumW-1).
  localparam int unsigned DivShift = (SumW - 1) + WinBits;
  localparam longint unsigned DivRecip =
    ((longint'(1) << DivShift) + longint'(Window) - 1) / longint'(Window);
  localparam int unsigned RecipW   = DivShift - WinBits + 1;
  localparam int unsigned ProdW    = (SumW - 1) + RecipW;
  localparam int unsigned QuotW    = SampleW;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [SumW-1:0]    sum_t;
  typedef logic [PosW-1:0]           pos_t;
  typedef logic [QuotW-1:0]          quot_t;
  typedef logic [OutW-1:0]           mag_t;

endpackage

[design/moving_average_motion_magnitude_core.sv]
// Moving-average motion magnitude core: per-axis window average and deviation sum.
//
//   channel  direction  handshake                  payload
//   in       sink       in_valid_i / in_stall_o    x_sample_i, y_sample_i, z_sample_i
//   out      source     out_valid_o / out_stall_i  motion_magnitude_o
//
// One transaction is accepted per cycle while the output is not stalled; each result passes
// through the input register, quotient register and result register before it is offered.
// The running sums and histories update in the accept cycle, so consecutive samples
// need no gap. Reset clears the histories, sums, write position and all valid bits.
// A stall on the output backs up through the pipeline; bubbles are squeezed out
// before the input channel is stalled.
`include "moving_average_motion_magnitude_core_defines.svh"

module moving_average_motion_magnitude_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [15:0]           x_sample_i,
  input  logic signed [15:0]           y_sample_i,
  input  logic signed [15:0]           z_sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [17:0]                  motion_magnitude_o
);

  // Pipeline control.
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic rdy_out, rdy2, rdy1, in_acc;

  // Window state.
  mamm_pkg::sample_t hist_q [mamm_pkg::NumAxes][mamm_pkg::Window];
  mamm_pkg::sum_t    sum_q  [mamm_pkg::NumAxes];
  mamm_pkg::sum_t    sum_d  [mamm_pkg::NumAxes];
  mamm_pkg::pos_t    pos_q, pos_d;

  // Stage payloads.
  mamm_pkg::sample_t in_sample [mamm_pkg::NumAxes];
  mamm_pkg::sample_t s1_sample_q [mamm_pkg::NumAxes];
  mamm_pkg::sum_t    s1_sum_q    [mamm_pkg::NumAxes];
  mamm_pkg::sample_t s2_sample_q [mamm_pkg::NumAxes];
  mamm_pkg::quot_t   s2_qmag_q   [mamm_pkg::NumAxes];
  logic              s2_neg_q    [mamm_pkg::NumAxes];
  mamm_pkg::quot_t   qmag_d      [mamm_pkg::NumAxes];
  logic              neg_d       [mamm_pkg::NumAxes];
  mamm_pkg::mag_t    mag_d, mag_q;
  logic              qmag_ok;

  assign in_sample[0] = x_sample_i;
  assign in_sample[1] = y_sample_i;
  assign in_sample[2] = z_sample_i;

  // Ready chain from the output register back to the input.
  assign rdy_out    = !out_valid_q || !out_stall_i;
  assign rdy2       = !s2_valid_q || rdy_out;
  assign rdy1       = !s1_valid_q || rdy2;
  assign in_stall_o = !rdy1;
  assign in_acc     = in_valid_i && rdy1;

  // Running sum update: add the new sample and drop the one it overwrites.
  always_comb begin
    for (int a = 0; a < mamm_pkg::NumAxes; a++) begin
      sum_d[a] = sum_q[a] + mamm_pkg::SumW'(in_sample[a])
               - mamm_pkg::SumW'(hist_q[a][pos_q]);
    end
    if (pos_q == mamm_pkg::PosW'(mamm_pkg::Window - 1)) begin
      pos_d = '0;
    end else begin
      pos_d = pos_q + mamm_pkg::PosW'(1);
    end
  end

  // Valid bits, histories, sums and write position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      for (int a = 0; a < mamm_pkg::NumAxes; a++) begin
        sum_q[a] <= '0;
        for (int i = 0; i < mamm_pkg::Window; i++) begin
          hist_q[a][i] <= '0;
        end
      end
    end else begin
      if (rdy1) begin
        s1_valid_q <= in_valid_i;
      end
      if (rdy2) begin
        s2_valid_q <= s1_valid_q;
      end
      if (rdy_out) begin
        out_valid_q <= s2_valid_q;
      end
      if (in_acc) begin
        pos_q <= pos_d;
        for (int a = 0; a < mamm_pkg::NumAxes; a++) begin
          sum_q[a]         <= sum_d[a];
          hist_q[a][pos_q] <= in_sample[a];
        end
      end
    end
  end

  // Divide each window sum by the window length, truncating toward zero.
  always_comb begin
    logic [mamm_pkg::SumW-2:0]  mag;
    logic [mamm_pkg::ProdW-1:0] prod;
    for (int a = 0; a < mamm_pkg::NumAxes; a++) begin
      neg_d[a] = s1_sum_q[a][mamm_pkg::SumW-1];
      if (neg_d[a]) begin
        mag = (mamm_pkg::SumW - 1)'(-s1_sum_q[a]);
      end else begin
        mag = s1_sum_q[a][mamm_pkg::SumW-2:0];
      end
      prod      = mamm_pkg::ProdW'(mag) * mamm_pkg::ProdW'(mamm_pkg::DivRecip);
      qmag_d[a] = prod[mamm_pkg::DivShift +: mamm_pkg::QuotW];
    end
  end

  // Sum of the three absolute deviations of sample from average.
  always_comb begin
    logic signed [mamm_pkg::SampleW:0]   avg;
    logic signed [mamm_pkg::SampleW+1:0] diff;
    logic [mamm_pkg::SampleW:0]          adiff;
    mag_d = '0;
    for (int a = 0; a < mamm_pkg::NumAxes; a++) begin
      if (s2_neg_q[a]) begin
        avg = -$signed({1'b0, s2_qmag_q[a]});
      end else begin
        avg = $signed({1'b0, s2_qmag_q[a]});
      end
      diff = (mamm_pkg::SampleW + 2)'(avg) - (mamm_pkg::SampleW + 2)'(s2_sample_q[a]);
      if (diff[mamm_pkg::SampleW+1]) begin
        adiff = (mamm_pkg::SampleW + 1)'(1) + (mamm_pkg::SampleW + 1)'(~diff);
      end else begin
        adiff = diff[mamm_pkg::SampleW:0];
      end
      mag_d = mag_d + mamm_pkg::OutW'(adiff);
    end
  end

  // Payload registers, loaded as each stage advances.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int a = 0; a < mamm_pkg::NumAxes; a++) begin
        s1_sample_q[a] <= in_sample[a];
        s1_sum_q[a]    <= sum_q[a];
      end
    end
    if (rdy2 && s1_valid_q) begin
      for (int a = 0; a < mamm_pkg::NumAxes; a++) begin
        s2_sample_q[a] <= s1_sample_q[a];
        s2_qmag_q[a]   <= qmag_d[a];
        s2_neg_q[a]    <= neg_d[a];
      end
    end
    if (rdy_out && s2_valid_q) begin
      mag_q <= mag_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign motion_magnitude_o = mag_q;

  // Every quotient magnitude stays within the sample range.
  always_comb begin
    qmag_ok = 1'b1;
    for (int a = 0; a < mamm_pkg::NumAxes; a++) begin
      if (s2_qmag_q[a] > mamm_pkg::QuotW'(1 << (mamm_pkg::SampleW - 1))) begin
        qmag_ok = 1'b0;
      end
    end
  end

  `MAMM_ASSERT_NOW(a_pos_range, 1'b1, pos_q < mamm_pkg::PosW'(mamm_pkg::Window))
  `MAMM_ASSERT_NEXT(a_accept_fills_stage, in_acc, s1_valid_q)
  `MAMM_ASSERT_NEXT(a_stalled_result_kept, out_valid_o && out_stall_i, out_valid_o)
  `MAMM_ASSERT_NOW(a_quotient_range, s2_valid_q, qmag_ok)

endmodule
